FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the row decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every clock edge outside reset.
`define BR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/br1rd_pkg.sv
// ----------------------------------------------------------------------------
// br1rd_pkg
// Types, constants and helper functions of the ByteRun1 row decoder.
// ----------------------------------------------------------------------------
package br1rd_pkg;

    localparam int MAX_ROW_BYTES = 4096;
    localparam int LANES         = 8;
    localparam int MAX_RESULTS   = 16;

    localparam int ROW_BYTES_W = 13;
    localparam int ROWCNT_W    = $clog2(MAX_ROW_BYTES + 1);

    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = 13'd40;
    localparam logic                   MODE_RST      = 1'b1;
    localparam logic [7:0]             SKIP_CODE     = 8'h80;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ROW_BYTES        = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_COMPRESSION_MODE = 1'b1;

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef struct packed {
        logic       resync;
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_bytes;
        logic [3:0]  byte_count;
        logic        row_done;
        logic        overrun_error;
        logic        last;
    } t_out_item;

    typedef enum logic [1:0] {
        PH_CTRL,
        PH_LIT,
        PH_REP,
        PH_ERR
    } t_phase;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_REP,
        CMD_ERR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
        logic [7:0] run_len;
        logic       row_end;
    } t_cmd;

    typedef struct packed {
        logic                   row_we;
        logic                   mode_we;
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic                   mode;
    } t_cfg_wr;

    typedef struct packed {
        logic [ROW_BYTES_W-1:0] row_bytes;
        logic                   mode;
    } t_cfg_view;

    // Effective row length: zero acts as one, clamp at the maximum.
    function automatic logic [ROWCNT_W-1:0] row_len(input logic [ROW_BYTES_W-1:0] rb);
        logic [ROWCNT_W-1:0] len;
        if (rb == '0) begin
            len = ROWCNT_W'(1);
        end else if (32'(rb) > 32'(MAX_ROW_BYTES)) begin
            len = ROWCNT_W'(MAX_ROW_BYTES);
        end else begin
            len = ROWCNT_W'(rb);
        end
        return len;
    endfunction

    // Bytes per result of a repeat run: widen the chunk when the run
    // would otherwise need more than MAX_RESULTS results.
    function automatic logic [3:0] rep_chunk(input logic [7:0] run);
        logic [3:0] per;
        if (32'(run) > 32'(MAX_RESULTS * LANES)) begin
            per = 4'((9'(run) + 9'(MAX_RESULTS - 1)) / 9'(MAX_RESULTS));
        end else begin
            per = 4'(LANES);
        end
        if (per > 4'd8) begin
            per = 4'd8;
        end
        if (per == 4'd0) begin
            per = 4'd1;
        end
        return per;
    endfunction

endpackage

FILE: hw/rtl/br1rd_front.sv
// ----------------------------------------------------------------------------
// br1rd_front
// Accepts stream bytes, tracks row and run state, issues output commands.
// ----------------------------------------------------------------------------
module br1rd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  br1rd_pkg::t_in_item i_item,
    input  logic                i_cmdq_full,
    input  br1rd_pkg::t_cfg_wr  i_cfg_wr,
    output logic                o_cmd_push,
    output br1rd_pkg::t_cmd     o_cmd,
    output br1rd_pkg::t_cfg_view o_cfg
);
    import br1rd_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [ROWCNT_W-1:0]    r_left, n_left;
    logic [7:0]             r_lit_left, n_lit_left;
    logic [7:0]             r_rep_len, n_rep_len;
    logic [ROW_BYTES_W-1:0] r_row_bytes, n_row_bytes;
    logic                   r_mode, n_mode;

    logic                accept;
    logic [ROWCNT_W-1:0] len_cur;
    t_phase              ph;
    logic [ROWCNT_W-1:0] left;
    logic [ROWCNT_W-1:0] left_dec;
    logic [7:0]          lit;
    logic [7:0]          lit_dec;
    logic [7:0]          rep;
    logic [7:0]          cnt;
    logic                row_end;

    assign accept = i_push && !i_cmdq_full;
    assign len_cur = row_len(r_row_bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CTRL;
            r_left      <= row_len(ROW_BYTES_RST);
            r_lit_left  <= '0;
            r_rep_len   <= '0;
            r_row_bytes <= ROW_BYTES_RST;
            r_mode      <= MODE_RST;
        end else begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_lit_left  <= n_lit_left;
            r_rep_len   <= n_rep_len;
            r_row_bytes <= n_row_bytes;
            r_mode      <= n_mode;
        end
    end

    always_comb begin
        // resync restarts the row before the byte is looked at
        ph  = r_phase;
        left = r_left;
        lit = r_lit_left;
        rep = r_rep_len;
        if (i_item.resync) begin
            ph   = PH_CTRL;
            left = len_cur;
            lit  = '0;
            rep  = '0;
        end
        left_dec = left - ROWCNT_W'(1);
        lit_dec  = lit - 8'd1;
        cnt      = i_item.byte_in[7] ? 8'(9'd257 - 9'(i_item.byte_in))
                                     : i_item.byte_in + 8'd1;
        row_end  = 1'b0;

        n_phase     = r_phase;
        n_left      = r_left;
        n_lit_left  = r_lit_left;
        n_rep_len   = r_rep_len;
        n_row_bytes = r_row_bytes;
        n_mode      = r_mode;

        o_cmd_push      = 1'b0;
        o_cmd.kind      = CMD_LIT;
        o_cmd.data      = i_item.byte_in;
        o_cmd.run_len   = '0;
        o_cmd.row_end   = 1'b0;

        if (accept) begin
            n_phase    = ph;
            n_left     = left;
            n_lit_left = lit;
            n_rep_len  = rep;
            if (!r_mode) begin
                row_end       = (left_dec == '0);
                o_cmd_push    = 1'b1;
                o_cmd.row_end = row_end;
                n_left        = row_end ? len_cur : left_dec;
                if (row_end) begin
                    n_phase    = PH_CTRL;
                    n_lit_left = '0;
                    n_rep_len  = '0;
                end
            end else begin
                case (ph)
                    PH_CTRL: begin
                        if (i_item.byte_in != SKIP_CODE) begin
                            if (32'(cnt) > 32'(left)) begin
                                o_cmd_push = 1'b1;
                                o_cmd.kind = CMD_ERR;
                                n_phase    = PH_ERR;
                            end else begin
                                n_left = left - ROWCNT_W'(cnt);
                                if (i_item.byte_in[7]) begin
                                    n_rep_len = cnt;
                                    n_phase   = PH_REP;
                                end else begin
                                    n_lit_left = cnt;
                                    n_phase    = PH_LIT;
                                end
                            end
                        end
                    end
                    PH_LIT: begin
                        o_cmd_push = 1'b1;
                        n_lit_left = lit_dec;
                        if (lit_dec == '0) begin
                            row_end       = (left == '0);
                            o_cmd.row_end = row_end;
                            n_phase       = PH_CTRL;
                            if (row_end) begin
                                n_left    = len_cur;
                                n_rep_len = '0;
                            end
                        end
                    end
                    PH_REP: begin
                        row_end       = (left == '0);
                        o_cmd_push    = 1'b1;
                        o_cmd.kind    = CMD_REP;
                        o_cmd.run_len = rep;
                        o_cmd.row_end = row_end;
                        n_phase       = PH_CTRL;
                        n_rep_len     = '0;
                        if (row_end) begin
                            n_left     = len_cur;
                            n_lit_left = '0;
                        end
                    end
                    default: begin
                        // error phase: drop the byte
                    end
                endcase
            end
        end

        // a register write restarts the row with the new settings
        if (i_cfg_wr.row_we || i_cfg_wr.mode_we) begin
            if (i_cfg_wr.row_we) begin
                n_row_bytes = i_cfg_wr.row_bytes;
            end
            if (i_cfg_wr.mode_we) begin
                n_mode = i_cfg_wr.mode;
            end
            n_phase    = PH_CTRL;
            n_left     = row_len(n_row_bytes);
            n_lit_left = '0;
            n_rep_len  = '0;
        end
    end

    assign o_cfg.row_bytes = r_row_bytes;
    assign o_cfg.mode      = r_mode;

endmodule

FILE: hw/rtl/br1rd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// br1rd_cmd_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module br1rd_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  br1rd_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output br1rd_pkg::t_cmd o_head
);
    import br1rd_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                 : r_wr_ptr + CMDQ_PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                                                                 : r_rd_ptr + CMDQ_PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CMDQ_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CMDQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `BR_ASSERT(a_no_push_when_full, i_clk, i_rst_n, !(i_push && o_full), "command dropped on full queue")
    `BR_ASSERT(a_no_pop_when_empty, i_clk, i_rst_n, !(i_pop && o_empty), "pop from empty command queue")

endmodule

FILE: hw/rtl/br1rd_back.sv
// ----------------------------------------------------------------------------
// br1rd_back
// Executes commands: emits literal bytes, expands repeat runs, flags errors.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module br1rd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmdq_empty,
    input  br1rd_pkg::t_cmd      i_head,
    output logic                 o_cmd_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output br1rd_pkg::t_out_item o_result
);
    import br1rd_pkg::*;

    // repeat expansion state
    logic       r_busy, n_busy;
    logic [7:0] r_byte, n_byte;
    logic [7:0] r_rem, n_rem;
    logic [3:0] r_per, n_per;
    logic       r_row_end, n_row_end;

    // result register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic        can_load;
    logic [7:0]  ch_byte;
    logic [7:0]  ch_rem;
    logic [3:0]  ch_per;
    logic        ch_row_end;
    logic [3:0]  ch_n;
    logic [7:0]  ch_rem_nx;
    logic        ch_fin;
    logic [63:0] ch_word;
    logic        emit_chunk;

    assign can_load = !r_out_valid || i_pop;

    always_comb begin
        ch_byte    = r_busy ? r_byte : i_head.data;
        ch_rem     = r_busy ? r_rem : i_head.run_len;
        ch_per     = r_busy ? r_per : rep_chunk(i_head.run_len);
        ch_row_end = r_busy ? r_row_end : i_head.row_end;
        ch_n       = (ch_rem < 8'(ch_per)) ? 4'(ch_rem) : ch_per;
        ch_rem_nx  = ch_rem - 8'(ch_n);
        ch_fin     = (ch_rem_nx == '0);
        for (int i = 0; i < 8; i++) begin
            ch_word[8*i +: 8] = (4'(i) < ch_n) ? ch_byte : 8'h00;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_byte      = r_byte;
        n_rem       = r_rem;
        n_per       = r_per;
        n_row_end   = r_row_end;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_pop;
        o_cmd_pop   = 1'b0;
        emit_chunk  = 1'b0;

        if (can_load) begin
            if (r_busy) begin
                emit_chunk = 1'b1;
            end else if (!i_cmdq_empty) begin
                o_cmd_pop = 1'b1;
                case (i_head.kind)
                    CMD_LIT: begin
                        n_out.out_bytes     = {56'd0, i_head.data};
                        n_out.byte_count    = 4'd1;
                        n_out.row_done      = i_head.row_end;
                        n_out.overrun_error = 1'b0;
                        n_out.last          = 1'b1;
                        n_out_valid         = 1'b1;
                    end
                    CMD_REP: begin
                        emit_chunk = 1'b1;
                    end
                    CMD_ERR: begin
                        n_out.out_bytes     = '0;
                        n_out.byte_count    = '0;
                        n_out.row_done      = 1'b0;
                        n_out.overrun_error = 1'b1;
                        n_out.last          = 1'b1;
                        n_out_valid         = 1'b1;
                    end
                    default: begin
                        // drop an undefined command
                    end
                endcase
            end
        end

        if (emit_chunk) begin
            n_out.out_bytes     = ch_word;
            n_out.byte_count    = ch_n;
            n_out.row_done      = ch_fin && ch_row_end;
            n_out.overrun_error = 1'b0;
            n_out.last          = ch_fin;
            n_out_valid         = 1'b1;
            n_busy              = !ch_fin;
            n_byte              = ch_byte;
            n_rem               = ch_rem_nx;
            n_per               = ch_per;
            n_row_end           = ch_row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte    <= n_byte;
        r_rem     <= n_rem;
        r_per     <= n_per;
        r_row_end <= n_row_end;
        r_out     <= n_out;
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

    `BR_ASSERT_IMP(a_busy_has_bytes, i_clk, i_rst_n, r_busy, r_rem != '0, "repeat run active with nothing left")
    `BR_ASSERT_IMP(a_error_is_empty, i_clk, i_rst_n, r_out_valid && r_out.overrun_error, (r_out.byte_count == '0) && r_out.last && !r_out.row_done, "error result carries bytes")
    `BR_ASSERT_IMP(a_no_new_cmd_while_busy, i_clk, i_rst_n, r_busy, !o_cmd_pop, "command taken during a repeat run")

endmodule

FILE: hw/rtl/byterun1_row_decoder_unit.sv
// ----------------------------------------------------------------------------
// byterun1_row_decoder_unit
// ByteRun1 (PackBits) row decoder with passthrough mode and APB registers.
// ----------------------------------------------------------------------------
// A compressed byte stream enters one beat per byte through a push/full port
// and leaves as decoded rows through an empty/pop port, in result beats of up
// to eight bytes. The front takes one byte every cycle while its four-entry
// command queue has room: control and skip bytes give no result, a literal
// byte gives one result and a repeat data byte gives ceil(run/8) results,
// so at most sixteen. The back emits one result per cycle into an output
// register while that register is empty or being popped; long repeat runs
// fill the command queue and then hold full high until the back drains them.
// A byte's command passes through the command queue, its result through the
// output register; a result can be popped once it shows there. A run that
// does not fit the rest of the row gives one error beat (byte_count zero,
// overrun_error set) and the decoder then drops every byte until one arrives
// with resync set, which restarts the row and is decoded as its first byte.
// Register 0 (address 0) holds the row length, where zero acts as one and
// values above the maximum row length are clamped; register 1 (address 4)
// selects passthrough (0) or ByteRun1 (1). Any register write restarts the
// row; write only while the decoder is idle.
// ----------------------------------------------------------------------------
module byterun1_row_decoder_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // compressed stream
    input  logic                                i_push,
    output logic                                o_full,
    input  br1rd_pkg::t_in_item                 i_item,
    // decoded results
    output logic                                o_empty,
    input  logic                                i_pop,
    output br1rd_pkg::t_out_item                o_result,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [br1rd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [br1rd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [br1rd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import br1rd_pkg::*;

    logic                 cmdq_full;
    logic                 cmdq_empty;
    logic                 cmd_push;
    logic                 cmd_pop;
    t_cmd                 cmd_in;
    t_cmd                 cmd_head;
    t_cfg_wr              cfg_wr;
    t_cfg_view            cfg_view;
    logic                 apb_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    // APB: zero wait states, register picked by the word address
    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:2];

    always_comb begin
        cfg_wr.row_we    = 1'b0;
        cfg_wr.mode_we   = 1'b0;
        cfg_wr.row_bytes = pwdata[ROW_BYTES_W-1:0];
        cfg_wr.mode      = pwdata[0];
        case (reg_idx)
            REG_ROW_BYTES:        cfg_wr.row_we  = apb_wr;
            REG_COMPRESSION_MODE: cfg_wr.mode_we = apb_wr;
            default: begin
                // no register at this address
            end
        endcase
    end

    always_comb begin
        case (reg_idx)
            REG_ROW_BYTES:        prdata = APB_DATA_W'(cfg_view.row_bytes);
            REG_COMPRESSION_MODE: prdata = APB_DATA_W'(cfg_view.mode);
            default:              prdata = '0;
        endcase
    end

    // the input side stalls only on a full command queue
    assign o_full = cmdq_full;

    br1rd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_item      (i_item),
        .i_cmdq_full (cmdq_full),
        .i_cfg_wr    (cfg_wr),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .o_cfg       (cfg_view)
    );

    br1rd_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .o_full  (cmdq_full),
        .i_pop   (cmd_pop),
        .o_empty (cmdq_empty),
        .o_head  (cmd_head)
    );

    br1rd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmdq_empty (cmdq_empty),
        .i_head       (cmd_head),
        .o_cmd_pop    (cmd_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_result     (o_result)
    );

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ByteRun1 row decoder unit.
// ----------------------------------------------------------------------------
// A short table of hand-picked bytes and register writes runs first. It covers
// skip, literal, repeat, overrun with resync recovery, passthrough and the
// row-length extremes. Segments of random packets follow, each under a fresh
// register setting. Every accepted byte goes through a local decoder model,
// and each popped beat is compared field by field with the oldest decoded
// beat still pending. Both queue ports idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import br1rd_pkg::*;

    localparam int DRAIN_CYCLES = 16;   // results trail their byte through the queue and output register
    localparam int HOLD_CYCLES  = 400;  // long pop hold-off to back the block up
    localparam int SEGMENTS     = 8;
    localparam int SEG_BYTES    = 24;
    localparam int N_DIRECTED   = 29;

    typedef enum logic [1:0] {
        DIR_BYTE,
        DIR_SET_ROW,
        DIR_SET_MODE
    } t_dir_op;

    // One line of the directed table. For a byte, value[7:0] is the stream
    // byte; for a register write it is the register value. A typed row carries
    // its single result beat, which replaces the model's beat.
    typedef struct packed {
        t_dir_op     op;
        logic        resync;
        logic [12:0] value;
        logic        typed;
        logic [63:0] bytes;
        logic [3:0]  count;
        logic        done;
        logic        err;
    } t_dir_row;

    // DUT ports; the inputs are known from time zero
    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_push  = 1'b0;
    logic                  o_full;
    t_in_item              i_item  = '0;
    logic                  o_empty;
    logic                  i_pop   = 1'b0;
    t_out_item             o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Decoder model state and its copy of the registers
    logic [ROW_BYTES_W-1:0] cfg_row_bytes = ROW_BYTES_RST;
    logic                   cfg_mode      = MODE_RST;
    t_phase                 dec_phase     = PH_CTRL;
    logic [12:0]            row_left      = '0;
    logic [7:0]             lit_left      = '0;
    logic [7:0]             run_len       = '0;

    t_out_item decoded_q [$];       // decoded beats not yet popped
    int        mismatch_count = 0;
    int        hold_req       = 0;  // pop hold-off requested from the feed side
    bit        steady         = 1'b0; // both sides run without idle cycles
    int        fed_bytes      = 0;  // bytes of this segment the decoder did not drop

    t_dir_row directed_rows [N_DIRECTED] = '{
        // skip byte after reset, then a one-byte literal
        '{DIR_BYTE,     1'b0, 13'h080, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h000, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h0FF, 1'b1, 64'hFF,   4'd1, 1'b0, 1'b0},
        // longest repeat overruns the 39 bytes left, next byte is dropped
        '{DIR_BYTE,     1'b0, 13'h081, 1'b1, 64'h0,    4'd0, 1'b0, 1'b1},
        '{DIR_BYTE,     1'b0, 13'h07F, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        // resync with a repeat that fills the whole 40-byte row
        '{DIR_BYTE,     1'b1, 13'h0D9, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h000, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        // zero row length acts as one
        '{DIR_SET_ROW,  1'b0, 13'd0,   1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h000, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h05A, 1'b1, 64'h5A,   4'd1, 1'b1, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h0FF, 1'b1, 64'h0,    4'd0, 1'b0, 1'b1},
        // oversized row length clamps to the maximum
        '{DIR_SET_ROW,  1'b0, 13'd8191, 1'b0, 64'h0,   4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b1, 13'h081, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h0FF, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h07F, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h0A5, 1'b1, 64'hA5,   4'd1, 1'b0, 1'b0},
        // resync abandons the open literal, the skip byte starts the new row
        '{DIR_BYTE,     1'b1, 13'h080, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        // passthrough
        '{DIR_SET_MODE, 1'b0, 13'd0,   1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h080, 1'b1, 64'h80,   4'd1, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b1, 13'h0FF, 1'b1, 64'hFF,   4'd1, 1'b0, 1'b0},
        '{DIR_SET_ROW,  1'b0, 13'd1,   1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h000, 1'b1, 64'h00,   4'd1, 1'b1, 1'b0},
        '{DIR_BYTE,     1'b1, 13'h0FF, 1'b1, 64'hFF,   4'd1, 1'b1, 1'b0},
        // back to ByteRun1 on a two-byte row: shortest repeat, overrun by one
        '{DIR_SET_MODE, 1'b0, 13'd1,   1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_SET_ROW,  1'b0, 13'd2,   1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h0FE, 1'b1, 64'h0,    4'd0, 1'b0, 1'b1},
        '{DIR_BYTE,     1'b1, 13'h0FF, 1'b0, 64'h0,    4'd0, 1'b0, 1'b0},
        '{DIR_BYTE,     1'b0, 13'h03C, 1'b1, 64'h3C3C, 4'd2, 1'b1, 1'b0},
        '{DIR_SET_ROW,  1'b0, 13'd4096, 1'b0, 64'h0,   4'd0, 1'b0, 1'b0}
    };

    byterun1_row_decoder_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_item   (i_item),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    // Row length in force: zero acts as one, clamp at the maximum.
    function automatic logic [12:0] eff_row_len();
        logic [12:0] len;
        len = cfg_row_bytes;
        if (len == '0) begin
            len = 13'd1;
        end else if (len > 13'(MAX_ROW_BYTES)) begin
            len = 13'(MAX_ROW_BYTES);
        end
        return len;
    endfunction

    function automatic void start_row();
        dec_phase = PH_CTRL;
        row_left  = eff_row_len();
        lit_left  = '0;
        run_len   = '0;
    endfunction

    // One decoded byte as its own beat; close the row on its last byte.
    function automatic void emit_byte(input logic [7:0] b, input logic row_end);
        t_out_item beat;
        beat            = '0;
        beat.out_bytes  = 64'(b);
        beat.byte_count = 4'd1;
        beat.row_done   = row_end;
        beat.last       = 1'b1;
        decoded_q.push_back(beat);
        if (row_end) begin
            start_row();
        end
    endfunction

    // Advance the model by one accepted byte and queue the beats it causes.
    // Return 1 when the byte is dropped in the error phase.
    function automatic logic decode_byte(input t_in_item it);
        t_out_item   beat;
        logic [8:0]  cnt;
        logic        row_end;
        int          per;
        int          left;
        int          n;
        if (it.resync) begin
            start_row();
        end
        if (!cfg_mode) begin
            row_left = row_left - 13'd1;
            emit_byte(it.byte_in, row_left == '0);
            return 1'b0;
        end
        beat = '0;
        case (dec_phase)
            PH_CTRL: begin
                if (it.byte_in != SKIP_CODE) begin
                    // negative control byte n repeats 1-n times
                    cnt = it.byte_in[7] ? 9'd257 - 9'(it.byte_in) : 9'(it.byte_in) + 9'd1;
                    if (13'(cnt) > row_left) begin
                        dec_phase          = PH_ERR;
                        beat.overrun_error = 1'b1;
                        beat.last          = 1'b1;
                        decoded_q.push_back(beat);
                    end else begin
                        row_left = row_left - 13'(cnt);
                        if (it.byte_in[7]) begin
                            run_len   = cnt[7:0];
                            dec_phase = PH_REP;
                        end else begin
                            lit_left  = cnt[7:0];
                            dec_phase = PH_LIT;
                        end
                    end
                end
            end
            PH_LIT: begin
                lit_left = lit_left - 8'd1;
                if (lit_left == '0) begin
                    dec_phase = PH_CTRL;
                    emit_byte(it.byte_in, row_left == '0);
                end else begin
                    emit_byte(it.byte_in, 1'b0);
                end
            end
            PH_REP: begin
                row_end = (row_left == '0);
                left    = int'(run_len);
                per     = LANES;
                // widen the beats when the run would need too many of them
                if ((left + per - 1) / per > MAX_RESULTS) begin
                    per = (left + MAX_RESULTS - 1) / MAX_RESULTS;
                end
                if (per > 8) begin
                    per = 8;
                end
                if (per < 1) begin
                    per = 1;
                end
                for (int k = 0; k < MAX_RESULTS && left > 0; k++) begin
                    n    = (left < per) ? left : per;
                    beat = '0;
                    for (int i = 0; i < n; i++) begin
                        beat.out_bytes[8*i +: 8] = it.byte_in;
                    end
                    left            = left - n;
                    beat.byte_count = 4'(n);
                    beat.last       = (left == 0);
                    beat.row_done   = (left == 0) && row_end;
                    decoded_q.push_back(beat);
                end
                run_len   = '0;
                dec_phase = PH_CTRL;
                if (row_end) begin
                    start_row();
                end
            end
            default: begin
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Compare one popped beat with the oldest pending decoded beat.
    task automatic check_beat(input t_out_item got);
        t_out_item want;
        if (decoded_q.size() == 0) begin
            flag_mismatch("beat with nothing pending", got.out_bytes, '0);
            return;
        end
        want = decoded_q.pop_front();
        if (got.out_bytes !== want.out_bytes) begin
            flag_mismatch("out_bytes", got.out_bytes, want.out_bytes);
        end
        if (got.byte_count !== want.byte_count) begin
            flag_mismatch("byte_count", 64'(got.byte_count), 64'(want.byte_count));
        end
        if (got.row_done !== want.row_done) begin
            flag_mismatch("row_done", 64'(got.row_done), 64'(want.row_done));
        end
        if (got.overrun_error !== want.overrun_error) begin
            flag_mismatch("overrun_error", 64'(got.overrun_error), 64'(want.overrun_error));
        end
        if (got.last !== want.last) begin
            flag_mismatch("last", 64'(got.last), 64'(want.last));
        end
    endtask

    // ------------------------------------------------------------------
    // Feed side
    // ------------------------------------------------------------------

    // Offer one byte and hold it until the block takes it. Push stays high
    // afterwards so that a back-to-back byte follows without a gap.
    task automatic push_beat(input t_in_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_full !== 1'b0);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic rs);
        t_in_item it;
        it.byte_in = b;
        it.resync  = rs;
        push_beat(it);
        if (!decode_byte(it)) begin
            fed_bytes++;
        end
    endtask

    // Drop push, wait for every pending beat, then let the block settle,
    // since a trailing control byte gives no beat to wait for.
    task automatic wait_drained();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write a register on an idle block, then read it back in the next
    // transfer without dropping psel.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [12:0] value);
        logic [APB_DATA_W-1:0] want;
        want = (idx == REG_ROW_BYTES) ? APB_DATA_W'(value) : APB_DATA_W'(value[0]);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        // the register took the value at this edge; any write restarts the row
        if (idx == REG_ROW_BYTES) begin
            cfg_row_bytes = value;
        end else begin
            cfg_mode = value[0];
        end
        start_row();
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== want) begin
            flag_mismatch("register read-back", 64'(prdata), 64'(want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One ByteRun1 packet, mostly well formed with random content, sized to
    // what is left of the row. The rest is noise, skips and overruns.
    task automatic send_packet();
        logic rs;
        int   room;
        int   top;
        int   cnt;
        int   pick;
        // finish a run that noise left open, resync now and then
        while (dec_phase == PH_LIT || dec_phase == PH_REP) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
        // leave the error phase through resync
        rs   = (dec_phase == PH_ERR) || ($urandom_range(0, 15) == 0);
        room = rs ? int'(eff_row_len()) : int'(row_left);
        top  = (room < 128) ? room : 128;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else if (pick < 3) begin
            send_byte(SKIP_CODE, rs);
        end else if (pick < 4 && room < 128) begin
            // run longer than the row has room for, as literal or repeat
            cnt = $urandom_range(room + 1, 128);
            send_byte($urandom_range(0, 1) ? 8'(cnt - 1) : 8'(257 - cnt), rs);
        end else if (pick < 12 || top < 2) begin
            cnt = ($urandom_range(0, 3) != 0) ? $urandom_range(1, (top < 8) ? top : 8)
                                              : $urandom_range(1, top);
            send_byte(8'(cnt - 1), rs);
            // a rare resync breaks the literal in the middle
            repeat (cnt) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 63) == 0);
        end else begin
            cnt = ($urandom_range(0, 3) != 0) ? $urandom_range(2, (top < 16) ? top : 16)
                                              : $urandom_range(2, top);
            send_byte(8'(257 - cnt), rs);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Pop side: stall at random, honor a long hold-off when asked
    // ------------------------------------------------------------------
    initial begin : pop_side
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end else begin
                stall = steady ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0) begin
                i_pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty !== 1'b0);
            check_beat(o_result);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : feed_side
        t_in_item    item;
        int          base;
        int          r;
        logic [12:0] len;
        start_row();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, starting from the reset settings
        foreach (directed_rows[k]) begin
            case (directed_rows[k].op)
                DIR_SET_ROW: begin
                    write_reg(REG_ROW_BYTES, directed_rows[k].value);
                end
                DIR_SET_MODE: begin
                    write_reg(REG_COMPRESSION_MODE, directed_rows[k].value);
                end
                default: begin
                    item.resync  = directed_rows[k].resync;
                    item.byte_in = directed_rows[k].value[7:0];
                    push_beat(item);
                    base = decoded_q.size();
                    void'(decode_byte(item));
                    if (directed_rows[k].typed) begin
                        // the table's own beat stands in for the model's
                        if (decoded_q.size() != base + 1) begin
                            flag_mismatch("directed beat count",
                                          64'(decoded_q.size() - base), 64'd1);
                        end else begin
                            decoded_q[base] = {directed_rows[k].bytes, directed_rows[k].count,
                                               directed_rows[k].done, directed_rows[k].err,
                                               1'b1};
                        end
                    end
                end
            endcase
        end

        // Random segments, each under its own register setting. Segment 1
        // holds pop off for a long stretch on a maximum-length row so the
        // block backs up and raises full; segment 2 pauses halfway until
        // every pending beat has come out.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            r = $urandom_range(0, 9);
            case (r)
                0:       len = 13'd0;
                1:       len = 13'd1;
                2:       len = 13'(MAX_ROW_BYTES);
                3:       len = 13'($urandom_range(MAX_ROW_BYTES + 1, 8191));
                default: len = 13'($urandom_range(2, 160));
            endcase
            if (seg == 1) begin
                len = 13'(MAX_ROW_BYTES);
            end
            write_reg(REG_ROW_BYTES, len);
            write_reg(REG_COMPRESSION_MODE,
                      (seg == 1) ? 13'd1 : 13'($urandom_range(0, 3) != 0));
            steady = (seg != 1) && ($urandom_range(0, 2) == 0);
            if (seg == 1) begin
                hold_req = HOLD_CYCLES;
            end
            fed_bytes = 0;
            for (int half = 1; half <= 2; half++) begin
                while (fed_bytes < half * SEG_BYTES / 2) begin
                    if (cfg_mode) begin
                        send_packet();
                    end else begin
                        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
                    end
                end
                if (half == 1 && seg == 2) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin : watchdog
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
